// File: hdl/tcf_pkg.sv
// tcf_pkg: shared types and constants of the client TCP connection state machine.
// Holds operation, result-kind, flag and state codes, and the front-to-back command word.
// No dependencies.
`default_nettype none

package tcf_pkg;

	// request codes carried in op
	localparam logic [1:0] OP_RECV = 2'd0;
	localparam logic [1:0] OP_OPEN = 2'd1;
	localparam logic [1:0] OP_SEND = 2'd2;

	// result kinds
	localparam logic [1:0] KIND_STATUS = 2'd0;
	localparam logic [1:0] KIND_TX     = 2'd1;
	localparam logic [1:0] KIND_RX     = 2'd2;

	// TCP flag bits
	localparam logic [8:0] FLAG_FIN = 9'h001;
	localparam logic [8:0] FLAG_SYN = 9'h002;
	localparam logic [8:0] FLAG_RST = 9'h004;
	localparam logic [8:0] FLAG_ACK = 9'h010;

	localparam logic [10:0] MAX_PAYLOAD  = 11'd1460;
	localparam logic [10:0] IP_HDR_BYTES = 11'd20;

	// TCP header words: plain header, or header with MSS option on SYN
	localparam logic [2:0]  OFF_PLAIN   = 3'd5;
	localparam logic [2:0]  OFF_MSS     = 3'd6;
	localparam logic [10:0] IPLEN_PLAIN = IP_HDR_BYTES + {6'd0, OFF_PLAIN, 2'b00};
	localparam logic [10:0] IPLEN_MSS   = IP_HDR_BYTES + {6'd0, OFF_MSS, 2'b00};

	// connection states
	localparam logic [2:0] ST_CLOSED        = 3'd0;
	localparam logic [2:0] ST_SYN_SENT      = 3'd1;
	localparam logic [2:0] ST_ESTABLISHED   = 3'd2;
	localparam logic [2:0] ST_FIN_WAIT1     = 3'd3;
	localparam logic [2:0] ST_FIN_WAIT2     = 3'd4;
	localparam logic [2:0] ST_PEER_CLOSED   = 3'd5;
	localparam logic [2:0] ST_AWAIT_FIN_ACK = 3'd6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	// classified request, front to back
	typedef struct packed {
		logic [1:0]  op;
		logic        port_hit;
		logic [8:0]  flags;       // received flags, or send flags for a send request
		logic [15:0] plen;        // received payload bytes, saturated at zero
		logic        plen_nz;
		logic [31:0] rack;
		logic [31:0] ack_one;     // remote_seq + 1
		logic [31:0] ack_data;    // remote_seq + payload bytes
		logic [10:0] send_inc;    // sequence advance of a send request
		logic [10:0] send_iplen;
		logic [2:0]  send_off;
	} cmd_t;

	// one result word
	typedef struct packed {
		logic [1:0]  kind;
		logic [8:0]  flags;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [2:0]  off;
		logic [10:0] iplen;
		logic [15:0] plen;
		logic [2:0]  state;
	} res_t;

endpackage

`default_nettype wire

// File: hdl/tcp_client_connection_fsm.sv
// tcp_client_connection_fsm: client-side TCP connection state machine for one socket.
// Top level; instantiates tcf_front, tcf_queue and tcf_back, uses tcf_pkg.
//
// Each accepted word is a received segment header (op 0), an open request (op 1) or a
// send request (op 2); it yields one or two result words, the final one marked by last.
// The input side takes one word per clock while in_stall is low: a registered
// classifier filters on local_port, extracts flags and computes the payload length, then
// hands a command into a 4-deep queue. The connection engine pops one command per clock
// while the output is not stalled and no second result is held, and keeps conn state,
// local seq and local ack. An established-state FIN or an established-state data segment
// yields two results; the second waits in a holding register, and no command is popped
// until it has moved to the output register. A word passes through the classifier stage,
// the queue and the output register. in_stall depends only on registered state (stage
// valid and queue occupancy). Write local_port only while the block is idle.
`default_nettype none

module tcp_client_connection_fsm import tcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: local_port
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	// request channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] dest_port,
	input  logic [15:0] offset_fields,
	input  logic [15:0] ip_total_length,
	input  logic [3:0]  ip_header_words,
	input  logic [31:0] remote_seq,
	input  logic [31:0] remote_ack,
	input  logic [8:0]  send_flags,
	input  logic [10:0] send_length,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [8:0]  tx_flags,
	output logic [31:0] tx_seq,
	output logic [31:0] tx_ack,
	output logic [2:0]  tx_data_offset,
	output logic [10:0] tx_ip_length,
	output logic [15:0] payload_length,
	output logic [2:0]  connection_state,
	output logic        last
);

	logic cmd_valid;
	cmd_t cmd_in;
	logic cmd_full;
	logic head_valid;
	cmd_t head;
	logic head_pop;
	res_t res;

	// classify: port filter, flag split, payload length, send sizing
	tcf_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.op              (op),
		.dest_port       (dest_port),
		.offset_fields   (offset_fields),
		.ip_total_length (ip_total_length),
		.ip_header_words (ip_header_words),
		.remote_seq      (remote_seq),
		.remote_ack      (remote_ack),
		.send_flags      (send_flags),
		.send_length     (send_length),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd_in),
		.cmd_full        (cmd_full)
	);

	// decouple: absorb output stalls while the classifier keeps taking words
	tcf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (cmd_valid),
		.push_data  (cmd_in),
		.full       (cmd_full),
		.pop_valid  (head_valid),
		.pop_data   (head),
		.pop        (head_pop)
	);

	// execute: state machine, seq/ack bookkeeping, result words
	tcf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (head_valid),
		.cmd       (head),
		.cmd_pop   (head_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res       (res),
		.res_last  (last)
	);

	assign kind             = res.kind;
	assign tx_flags         = res.flags;
	assign tx_seq           = res.seq;
	assign tx_ack           = res.ack;
	assign tx_data_offset   = res.off;
	assign tx_ip_length     = res.iplen;
	assign payload_length   = res.plen;
	assign connection_state = res.state;

endmodule

`default_nettype wire

// File: hdl/tcf_front.sv
// tcf_front: accepts request words, filters on the local port and classifies them.
// Holds the local_port register and one registered stage; uses tcf_pkg.
`default_nettype none

module tcf_front import tcf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [15:0] dest_port,
	input  logic [15:0] offset_fields,
	input  logic [15:0] ip_total_length,
	input  logic [3:0]  ip_header_words,
	input  logic [31:0] remote_seq,
	input  logic [31:0] remote_ack,
	input  logic [8:0]  send_flags,
	input  logic [10:0] send_length,
	output logic        cmd_valid,
	output cmd_t        cmd,
	input  logic        cmd_full
);

	logic [15:0] local_port_q;
	logic        valid_s1;
	cmd_t        cmd_s1;
	cmd_t        cls;
	logic        advance;
	logic [6:0]  hdr_sum;
	logic [15:0] plen;
	logic [10:0] len_sat;
	logic        bump;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_port_q <= '0;
		end else if (cfg_we) begin
			local_port_q <= cfg_wdata;
		end
	end

	always_comb begin
		hdr_sum = {1'b0, offset_fields[15:12], 2'b00} + {1'b0, ip_header_words, 2'b00};
		if (ip_total_length >= {9'd0, hdr_sum}) begin
			plen = ip_total_length - {9'd0, hdr_sum};
		end else begin
			plen = '0;
		end
		len_sat = (send_length > MAX_PAYLOAD) ? MAX_PAYLOAD : send_length;
		bump    = |(send_flags & (FLAG_FIN | FLAG_SYN));

		cls.op         = op;
		cls.port_hit   = (dest_port == local_port_q);
		cls.flags      = (op == OP_SEND) ? send_flags : offset_fields[8:0];
		cls.plen       = plen;
		cls.plen_nz    = (plen != 16'd0);
		cls.rack       = remote_ack;
		cls.ack_one    = remote_seq + 32'd1;
		cls.ack_data   = remote_seq + {16'd0, plen};
		cls.send_inc   = len_sat + {10'd0, bump};
		cls.send_off   = (|(send_flags & FLAG_SYN)) ? OFF_MSS : OFF_PLAIN;
		cls.send_iplen = IP_HDR_BYTES + {6'd0, cls.send_off, 2'b00} + len_sat;
	end

	// stage advances when empty or when the queue takes its word
	assign advance  = !valid_s1 || !cmd_full;
	assign in_stall = !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && in_valid) begin
			cmd_s1 <= cls;
		end
	end

	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

endmodule

`default_nettype wire

// File: hdl/tcf_queue.sv
// tcf_queue: short command queue between the classifier and the connection engine.
// Register-file FIFO of QUEUE_DEPTH cmd_t words; uses tcf_pkg.
`default_nettype none

module tcf_queue import tcf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	input  cmd_t push_data,
	output logic full,
	output logic pop_valid,
	output cmd_t pop_data,
	input  logic pop
);

	cmd_t                mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0] wr_ptr_q;
	logic [QUEUE_AW-1:0] rd_ptr_q;
	logic [QUEUE_AW:0]   cnt_q;
	logic                push;

	assign full      = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign push      = push_valid && !full;
	assign pop_valid = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (QUEUE_AW+1)'(QUEUE_DEPTH))
		else $error("queue count above depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> pop_valid)
		else $error("pop from empty queue");
	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count lost a push");
`endif

endmodule

`default_nettype wire

// File: hdl/tcf_back.sv
// tcf_back: connection engine; runs the state machine and builds the result words.
// Holds state, local seq/ack, the output register and a second-result holding register.
// Uses tcf_pkg.
`default_nettype none

module tcf_back import tcf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic out_valid,
	input  logic out_stall,
	output res_t res,
	output logic res_last
);

	logic [2:0]  st_q;
	logic [31:0] seq_q;
	logic [31:0] ack_q;
	logic        out_v_q;
	res_t        out_q;
	logic        out_last_q;
	logic        pend_v_q;
	res_t        pend_q;

	logic [2:0]  st_n;
	logic [31:0] seq_n;
	logic [31:0] ack_n;
	res_t        r0;
	res_t        r1;
	logic        two;
	logic        emit;
	logic        f_fin;
	logic        f_syn;
	logic        f_rst;
	logic        f_ack;
	logic        load_ok;

	function automatic res_t tx_res(input logic [8:0] f, input logic [31:0] s,
			input logic [31:0] a, input logic [2:0] o, input logic [10:0] l,
			input logic [2:0] st);
		res_t r;
		r.kind  = KIND_TX;
		r.flags = f;
		r.seq   = s;
		r.ack   = a;
		r.off   = o;
		r.iplen = l;
		r.plen  = '0;
		r.state = st;
		return r;
	endfunction

	function automatic res_t status_res(input logic [2:0] st);
		res_t r;
		r       = '0;
		r.kind  = KIND_STATUS;
		r.state = st;
		return r;
	endfunction

	assign f_fin = |(cmd.flags & FLAG_FIN);
	assign f_syn = |(cmd.flags & FLAG_SYN);
	assign f_rst = |(cmd.flags & FLAG_RST);
	assign f_ack = |(cmd.flags & FLAG_ACK);

	always_comb begin
		st_n  = st_q;
		seq_n = seq_q;
		ack_n = ack_q;
		r0    = status_res(st_q);
		r1    = status_res(st_q);
		two   = 1'b0;
		emit  = 1'b0;
		case (cmd.op)
			OP_OPEN: begin
				if (st_q == ST_CLOSED) begin
					st_n  = ST_SYN_SENT;
					seq_n = seq_q + 32'd1;
					r0    = tx_res(FLAG_SYN, seq_q, ack_q, OFF_MSS, IPLEN_MSS, ST_SYN_SENT);
					emit  = 1'b1;
				end
			end
			OP_SEND: begin
				if (f_fin && st_q == ST_ESTABLISHED) begin
					st_n = ST_FIN_WAIT1;
				end
				seq_n = seq_q + {21'd0, cmd.send_inc};
				r0    = tx_res(cmd.flags, seq_q, ack_q, cmd.send_off, cmd.send_iplen, st_n);
				emit  = 1'b1;
			end
			OP_RECV: begin
				if (cmd.port_hit) begin
					case (st_q)
						ST_SYN_SENT: begin
							if (f_syn && f_ack) begin
								st_n  = ST_ESTABLISHED;
								seq_n = cmd.rack;
								ack_n = cmd.ack_one;
								r0    = tx_res(FLAG_ACK, cmd.rack, cmd.ack_one, OFF_PLAIN,
									IPLEN_PLAIN, ST_ESTABLISHED);
								emit  = 1'b1;
							end else if (f_rst) begin
								st_n = ST_CLOSED;
							end
						end
						ST_ESTABLISHED: begin
							if (f_rst) begin
								st_n = ST_CLOSED;
							end else if (f_fin) begin
								// ack the FIN, then close our side right away
								st_n  = ST_AWAIT_FIN_ACK;
								ack_n = cmd.ack_one;
								seq_n = seq_q + 32'd1;
								r0    = tx_res(FLAG_ACK, seq_q, cmd.ack_one, OFF_PLAIN,
									IPLEN_PLAIN, ST_PEER_CLOSED);
								r1    = tx_res(FLAG_FIN | FLAG_ACK, seq_q, cmd.ack_one,
									OFF_PLAIN, IPLEN_PLAIN, ST_AWAIT_FIN_ACK);
								two   = 1'b1;
								emit  = 1'b1;
							end else if (f_ack) begin
								seq_n = cmd.rack;
								if (cmd.plen_nz) begin
									ack_n      = cmd.ack_data;
									r0         = '0;
									r0.kind    = KIND_RX;
									r0.plen    = cmd.plen;
									r0.state   = ST_ESTABLISHED;
									r1         = tx_res(FLAG_ACK, cmd.rack, cmd.ack_data,
										OFF_PLAIN, IPLEN_PLAIN, ST_ESTABLISHED);
									two        = 1'b1;
									emit       = 1'b1;
								end
							end
						end
						ST_FIN_WAIT1: begin
							if (f_fin && f_ack) begin
								st_n  = ST_CLOSED;
								ack_n = cmd.ack_one;
								r0    = tx_res(FLAG_ACK, seq_q, cmd.ack_one, OFF_PLAIN,
									IPLEN_PLAIN, ST_CLOSED);
								emit  = 1'b1;
							end else if (f_ack) begin
								st_n = ST_FIN_WAIT2;
							end
						end
						ST_FIN_WAIT2: begin
							if (f_fin) begin
								st_n  = ST_CLOSED;
								ack_n = cmd.ack_one;
								r0    = tx_res(FLAG_ACK, seq_q, cmd.ack_one, OFF_PLAIN,
									IPLEN_PLAIN, ST_CLOSED);
								emit  = 1'b1;
							end
						end
						ST_AWAIT_FIN_ACK: begin
							if (f_ack) begin
								st_n = ST_CLOSED;
							end
						end
						default: begin
						end
					endcase
				end
			end
			default: begin
			end
		endcase
		if (!emit) begin
			r0 = status_res(st_n);
		end
	end

	// output register free now, or freed by the taker this cycle
	assign load_ok = !out_v_q || !out_stall;
	assign cmd_pop = cmd_valid && !pend_v_q && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLOSED;
			seq_q    <= '0;
			ack_q    <= '0;
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (cmd_pop) begin
				st_q  <= st_n;
				seq_q <= seq_n;
				ack_q <= ack_n;
			end
			if (load_ok) begin
				if (pend_v_q) begin
					out_v_q  <= 1'b1;
					pend_v_q <= 1'b0;
				end else begin
					out_v_q  <= cmd_pop;
					pend_v_q <= cmd_pop && two;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			if (pend_v_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b1;
			end else if (cmd_pop) begin
				out_q      <= r0;
				out_last_q <= !two;
				pend_q     <= r1;
			end
		end
	end

	assign out_valid = out_v_q;
	assign res       = out_q;
	assign res_last  = out_last_q;

`ifndef SYNTHESIS
	a_pend_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_v_q |-> out_v_q)
		else $error("second result held without a first one in the output register");
	a_first_has_partner: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && !out_last_q) |-> pend_v_q)
		else $error("non-final result shown with no second result pending");
	a_state_on_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_pop |=> $stable(st_q) && $stable(seq_q) && $stable(ack_q))
		else $error("connection state moved without a command");
`endif

endmodule

`default_nettype wire
